// File: hdl/cbt_pkg.sv
// cubic bezier tessellator: shared constants and the bernstein weight table
// no dependencies; used by the interfaces and all modules
package cbt_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int SEGMENTS       = 16;
  localparam int WEIGHT_SHIFT   = 12;
  localparam int WEIGHT_W       = 13;
  localparam int STEP_W         = 5;
  localparam int NUM_PTS        = 4;
  localparam int NUM_AXES       = 3;
  localparam int QUEUE_DEPTH    = 2;

  // weight index names
  localparam logic [1:0] W_START = 2'd0;
  localparam logic [1:0] W_NEAR  = 2'd1;
  localparam logic [1:0] W_FAR   = 2'd2;
  localparam logic [1:0] W_END   = 2'd3;

  // integer bernstein weight over 4096 for step s (t = s/16); narrow input, acts as a rom
  function automatic logic [WEIGHT_W-1:0] bern_weight(input logic [1:0] k,
                                                      input logic [STEP_W-1:0] s);
    logic [14:0] r;
    logic [14:0] t;
    logic [14:0] v;
    r = 15'(SEGMENTS) - 15'(s);
    t = 15'(s);
    case (k)
      W_START: v = r * r * r;
      W_NEAR:  v = 15'd3 * r * r * t;
      W_FAR:   v = 15'd3 * r * t * t;
      W_END:   v = t * t * t;
      default: v = '0;
    endcase
    return v[WEIGHT_W-1:0];
  endfunction

endpackage

// File: hdl/cbt_curve_if.sv
// curve channel: valid/ready handshake carrying four 3d control points
// depends on cbt_pkg
interface cbt_curve_if import cbt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] start_z;
  logic signed [COORD_BITS-1:0] near_ctrl_x;
  logic signed [COORD_BITS-1:0] near_ctrl_y;
  logic signed [COORD_BITS-1:0] near_ctrl_z;
  logic signed [COORD_BITS-1:0] far_ctrl_x;
  logic signed [COORD_BITS-1:0] far_ctrl_y;
  logic signed [COORD_BITS-1:0] far_ctrl_z;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic signed [COORD_BITS-1:0] end_z;

  modport source (
    output valid, start_x, start_y, start_z, near_ctrl_x, near_ctrl_y, near_ctrl_z,
           far_ctrl_x, far_ctrl_y, far_ctrl_z, end_x, end_y, end_z,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, start_z, near_ctrl_x, near_ctrl_y, near_ctrl_z,
           far_ctrl_x, far_ctrl_y, far_ctrl_z, end_x, end_y, end_z,
    output ready
  );
endinterface

// File: hdl/cbt_point_if.sv
// point channel: valid/ready handshake carrying one tessellated curve point
// depends on cbt_pkg
interface cbt_point_if import cbt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic [STEP_W-1:0]            step_number;
  logic                         last_point;

  modport source (
    output valid, point_x, point_y, point_z, step_number, last_point,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, step_number, last_point,
    output ready
  );
endinterface

// File: hdl/cbt_front.sv
// front end: takes curves from the input channel into a two-entry queue
// depends on cbt_pkg and cbt_curve_if
module cbt_front import cbt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int CURVE_W   = NUM_PTS * NUM_AXES * COORD_BITS
) (
  input  logic               clk,
  input  logic               rst,
  cbt_curve_if.sink          curve,
  output logic               q_valid,
  output logic [CURVE_W-1:0] q_curve,
  input  logic               q_pop
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [CURVE_W-1:0] entry [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;
  logic [CURVE_W-1:0] packed_in;

  // point k, axis a sits at slice (k*3 + a)
  assign packed_in = {curve.end_z, curve.end_y, curve.end_x,
                      curve.far_ctrl_z, curve.far_ctrl_y, curve.far_ctrl_x,
                      curve.near_ctrl_z, curve.near_ctrl_y, curve.near_ctrl_x,
                      curve.start_z, curve.start_y, curve.start_x};

  // no transfer is taken while reset is held
  assign curve.ready = !rst && (count != CNT_W'(QUEUE_DEPTH));
  assign push        = curve.valid && curve.ready;
  assign q_valid     = (count != '0);
  assign pop         = q_pop && q_valid;
  assign q_curve     = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= packed_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

// File: hdl/cbt_back.sv
// back end: steps through t = i/16, multiplies weights by the control points,
// sums and rounds into the output register; depends on cbt_pkg and cbt_point_if
module cbt_back import cbt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int CURVE_W   = NUM_PTS * NUM_AXES * COORD_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  logic [CURVE_W-1:0] q_curve,
  output logic               q_pop,
  cbt_point_if.source        point
);

  localparam int PROD_W = COORD_BITS + WEIGHT_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int CNT_W  = $clog2(SEGMENTS);

  logic [CNT_W-1:0]         cnt;
  logic [STEP_W-1:0]        issue_step;
  logic                     advance;
  logic                     issue;
  logic signed [PROD_W-1:0] prod_next [NUM_AXES][NUM_PTS];

  logic                     s1_valid;
  logic [STEP_W-1:0]        s1_step;
  logic signed [PROD_W-1:0] s1_prod [NUM_AXES][NUM_PTS];

  logic signed [COORD_BITS-1:0] coord_next [NUM_AXES];
  logic                         out_valid;

  // whole pipeline moves when the output register is free or being drained
  assign advance    = !out_valid || point.ready;
  assign issue      = q_valid && advance;
  assign issue_step = STEP_W'(cnt) + 1'b1;
  assign q_pop      = issue && (cnt == CNT_W'(SEGMENTS - 1));

  always_comb begin
    logic signed [PROD_W-1:0] w_ext;
    logic signed [PROD_W-1:0] c_ext;
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int k = 0; k < NUM_PTS; k++) begin
        w_ext = PROD_W'(bern_weight(2'(k), issue_step));
        c_ext = PROD_W'($signed(q_curve[(k * NUM_AXES + a) * COORD_BITS +: COORD_BITS]));
        prod_next[a][k] = w_ext * c_ext;
      end
    end
  end

  // floor((sum + 2048) / 4096); the result always lies within the input range
  always_comb begin
    logic signed [SUM_W-1:0] sum;
    for (int a = 0; a < NUM_AXES; a++) begin
      sum = SUM_W'(1) <<< (WEIGHT_SHIFT - 1);
      for (int k = 0; k < NUM_PTS; k++) begin
        sum = sum + SUM_W'(s1_prod[a][k]);
      end
      coord_next[a] = COORD_BITS'(sum >>> WEIGHT_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= issue;
      out_valid <= s1_valid;
      if (issue) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_step <= issue_step;
      s1_prod <= prod_next;
      point.point_x     <= coord_next[0];
      point.point_y     <= coord_next[1];
      point.point_z     <= coord_next[2];
      point.step_number <= s1_step;
      point.last_point  <= (s1_step == STEP_W'(SEGMENTS));
    end
  end

  assign point.valid = out_valid;

endmodule

// File: hdl/cubic_bezier_tessellator_unit.sv
// cubic bezier tessellator top level: input queue feeding the point pipeline
// depends on cbt_pkg, cbt_curve_if, cbt_point_if, cbt_front, cbt_back
//
//   port    role  carries
//   curve   sink  one cubic segment: start, near_ctrl, far_ctrl, end (x, y, z)
//   point   src   one of 16 points per segment, step_number 1..16, last_point
//
// sixteen points per curve, one point per cycle while point is not stalled;
// the back end issues one step per cycle, which sets that rate
// point valid follows the queue, s1_prod and output registers, in that order
// a two-entry queue takes further curves while earlier ones are still in work
// a point stall freezes the pipeline; curve stalls only if queue full or in reset
// synchronous reset clears the queue and pipeline valid bits
module cubic_bezier_tessellator_unit import cbt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  cbt_curve_if.sink   curve,
  cbt_point_if.source point
);

  localparam int CURVE_W = NUM_PTS * NUM_AXES * COORD_BITS;

  logic               q_valid;
  logic [CURVE_W-1:0] q_curve;
  logic               q_pop;

  cbt_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .curve   (curve),
    .q_valid (q_valid),
    .q_curve (q_curve),
    .q_pop   (q_pop)
  );

  cbt_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_curve (q_curve),
    .q_pop   (q_pop),
    .point   (point)
  );

  // last flag marks exactly the sixteenth step
  a_last_step: assert property (@(posedge clk) disable iff (rst)
    point.valid |-> (point.last_point == (point.step_number == STEP_W'(SEGMENTS))))
    else $error("last_point does not match step 16");

  // steps run in order within a curve
  a_step_order: assert property (@(posedge clk) disable iff (rst)
    (point.valid && point.ready && !point.last_point) |=>
      (!point.valid || point.step_number == $past(point.step_number) + 1'b1))
    else $error("step_number out of sequence");

  // a point never carries step zero
  a_step_nonzero: assert property (@(posedge clk) disable iff (rst)
    point.valid |-> (point.step_number != '0))
    else $error("step_number is zero");

  // the queue is pulled only while it holds a curve
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue pulled while empty");

endmodule
